[src/gwdf_pkg.sv]
// Shared types, codes and defaults for the grid wavefront distance fill block.
package gwdf_pkg;

	localparam int DEF_MAX_ROWS  = 64;
	localparam int DEF_MAX_COLS  = 64;
	localparam int DEF_DIST_BITS = 8;

	localparam int ROW_W      = 6;
	localparam int COL_W      = 6;
	localparam int DIR_W      = 3;
	localparam int DIST_OUT_W = 8;
	localparam int CFG_W      = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int GRID_CFG_W = 7;

	localparam int RST_GRID_ROWS = 64;
	localparam int RST_GRID_COLS = 64;
	localparam int RST_LIMIT     = 255;

	localparam logic [1:0] CMD_WRITE  = 2'd0;
	localparam logic [1:0] CMD_FILL   = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 2'd2;

	// neighbor select doubles as the direction code
	localparam logic [DIR_W-1:0] SEL_CENTER = 3'd0;
	localparam logic [DIR_W-1:0] SEL_UP     = 3'd1;
	localparam logic [DIR_W-1:0] SEL_DOWN   = 3'd2;
	localparam logic [DIR_W-1:0] SEL_LEFT   = 3'd3;
	localparam logic [DIR_W-1:0] SEL_RIGHT  = 3'd4;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             blocked;
	} item_t;

	typedef struct packed {
		logic [DIR_W-1:0]      direction;
		logic [DIST_OUT_W-1:0] distance;
		logic                  is_wall;
		logic                  goal_inside;
	} result_t;

	typedef struct packed {
		logic             accept;
		logic             init_clr;
		logic             fill_clr;
		logic             wr_cell;
		logic             base_cur;
		logic [DIR_W-1:0] sel;
		logic             seed;
		logic             wall_res;
		logic             q_init;
		logic             q_pop;
		logic             cur_load;
		logic             relax;
		logic             q_eval;
		logic             publish;
	} ctl_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       in_grid;
		logic       sweep_last;
		logic       q_empty;
		logic       cur_stop;
		logic       rd_wall;
		logic       out_free;
	} status_t;

endpackage

[src/gwdf_ctrl.sv]
// Sequencer for write, fill and query commands of the wavefront fill block.
module gwdf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  gwdf_pkg::status_t st,
	output gwdf_pkg::ctl_t    ctl
);

	localparam logic [3:0] S_INIT = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_DEC  = 4'd2;
	localparam logic [3:0] S_CLR  = 4'd3;
	localparam logic [3:0] S_GRD  = 4'd4;
	localparam logic [3:0] S_GCHK = 4'd5;
	localparam logic [3:0] S_POP  = 4'd6;
	localparam logic [3:0] S_LD   = 4'd7;
	localparam logic [3:0] S_NRD  = 4'd8;
	localparam logic [3:0] S_NCHK = 4'd9;
	localparam logic [3:0] S_QRD  = 4'd10;
	localparam logic [3:0] S_QCHK = 4'd11;
	localparam logic [3:0] S_FIN  = 4'd12;

	logic [3:0] state_q, state_d;
	logic [gwdf_pkg::DIR_W-1:0] k_q, k_d;

	assign item_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		ctl     = '0;
		ctl.sel = k_q;
		unique case (state_q)
			S_INIT: begin
				ctl.init_clr = 1'b1;
				if (st.sweep_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (item_valid) begin
					ctl.accept = 1'b1;
					state_d    = S_DEC;
				end
			end
			S_DEC: begin
				unique case (st.cmd)
					gwdf_pkg::CMD_WRITE: begin
						ctl.wr_cell = 1'b1;
						state_d     = S_FIN;
					end
					gwdf_pkg::CMD_FILL: state_d = S_CLR;
					gwdf_pkg::CMD_QUERY: begin
						k_d     = gwdf_pkg::SEL_CENTER;
						state_d = st.in_grid ? S_QRD : S_FIN;
					end
					default: state_d = S_FIN;
				endcase
			end
			S_CLR: begin
				ctl.fill_clr = 1'b1;
				if (st.sweep_last) begin
					ctl.q_init = 1'b1;
					state_d    = st.in_grid ? S_GRD : S_FIN;
				end
			end
			S_GRD: begin
				ctl.sel = gwdf_pkg::SEL_CENTER;
				state_d = S_GCHK;
			end
			S_GCHK: begin
				if (st.rd_wall) begin
					ctl.wall_res = 1'b1;
					state_d      = S_FIN;
				end else begin
					ctl.seed = 1'b1;
					state_d  = S_POP;
				end
			end
			S_POP: begin
				if (st.q_empty) begin
					state_d = S_FIN;
				end else begin
					ctl.q_pop = 1'b1;
					state_d   = S_LD;
				end
			end
			S_LD: begin
				ctl.cur_load = 1'b1;
				k_d          = gwdf_pkg::SEL_UP;
				state_d      = st.cur_stop ? S_POP : S_NRD;
			end
			S_NRD: begin
				ctl.base_cur = 1'b1;
				state_d      = S_NCHK;
			end
			S_NCHK: begin
				ctl.relax = 1'b1;
				if (k_q == gwdf_pkg::SEL_RIGHT) begin
					state_d = S_POP;
				end else begin
					k_d     = k_q + 1'b1;
					state_d = S_NRD;
				end
			end
			S_QRD: state_d = S_QCHK;
			S_QCHK: begin
				ctl.q_eval = 1'b1;
				if (k_q == gwdf_pkg::SEL_RIGHT) begin
					state_d = S_FIN;
				end else begin
					k_d     = k_q + 1'b1;
					state_d = S_QRD;
				end
			end
			S_FIN: begin
				if (st.out_free) begin
					ctl.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			k_q     <= gwdf_pkg::SEL_CENTER;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
		end
	end

endmodule

[src/gwdf_dp.sv]
// Datapath: cell memories, frontier queue, config registers and result register.
module gwdf_dp #(
	parameter int MAX_ROWS  = gwdf_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS  = gwdf_pkg::DEF_MAX_COLS,
	parameter int DIST_BITS = gwdf_pkg::DEF_DIST_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  gwdf_pkg::item_t                   item,
	input  logic                              result_stall,
	output logic                              result_valid,
	output gwdf_pkg::result_t                 result,
	input  logic                              cfg_we,
	input  logic [gwdf_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [gwdf_pkg::CFG_W-1:0]        cfg_wdata,
	input  gwdf_pkg::ctl_t                    ctl,
	output gwdf_pkg::status_t                 st
);

	localparam int RB    = $clog2(MAX_ROWS);
	localparam int CB    = $clog2(MAX_COLS);
	localparam int AW    = RB + CB;
	localparam int DEPTH = 1 << AW;
	// one spare bit so that row+1 and col+1 never wrap
	localparam int RW    = ((RB > gwdf_pkg::ROW_W) ? RB : gwdf_pkg::ROW_W) + 1;
	localparam int CW    = ((CB > gwdf_pkg::COL_W) ? CB : gwdf_pkg::COL_W) + 1;
	localparam int DIST_MAX  = (1 << DIST_BITS) - 1;
	localparam int RST_ROWS  = (gwdf_pkg::RST_GRID_ROWS > MAX_ROWS) ? MAX_ROWS
	                                                                : gwdf_pkg::RST_GRID_ROWS;
	localparam int RST_COLS  = (gwdf_pkg::RST_GRID_COLS > MAX_COLS) ? MAX_COLS
	                                                                : gwdf_pkg::RST_GRID_COLS;
	localparam int RST_LIM   = (gwdf_pkg::RST_LIMIT > DIST_MAX) ? DIST_MAX
	                                                            : gwdf_pkg::RST_LIMIT;
	localparam int DO_W = gwdf_pkg::DIST_OUT_W;
	localparam int QW   = AW + DIST_BITS;

	// memories
	logic                 wall_mem [DEPTH];
	logic [DIST_BITS-1:0] dist_mem [DEPTH];
	logic [QW-1:0]        queue_mem [DEPTH];

	// config
	logic [RW-1:0]        rows_q;
	logic [CW-1:0]        cols_q;
	logic [DIST_BITS-1:0] lim_q;
	int unsigned          rows_v, cols_v, lim_v;

	// control registers
	logic [AW-1:0]        sweep_q;
	logic [AW:0]          head_q, tail_q;
	logic                 result_valid_q;

	// payload registers
	gwdf_pkg::item_t      item_q;
	logic                 inside_q;
	logic [AW-1:0]        cur_addr_q;
	logic [DIST_BITS-1:0] cur_d_q;
	logic                 wall_rd_q, ok_rd_q;
	logic [DIST_BITS-1:0] dist_rd_q;
	logic [AW-1:0]        addr_rd_q;
	logic [QW-1:0]        qd_rd_q;
	logic [gwdf_pkg::DIR_W-1:0] res_dir_q;
	logic [DIST_BITS-1:0] res_dist_q, best_q;
	logic                 res_wall_q, res_goal_q;
	gwdf_pkg::result_t    result_q;

	// combinational
	logic [RW-1:0]        row_in, base_r, nb_r;
	logic [CW-1:0]        col_in, base_c, nb_c;
	logic                 nb_ok, inside_in;
	logic [AW-1:0]        nb_addr, item_addr;
	logic [DIST_BITS-1:0] d_next, cand;
	logic                 relax_go, q_push;
	logic [QW-1:0]        q_wdata;
	logic                 dist_we, wall_we, wall_wdata;
	logic [AW-1:0]        dist_waddr, wall_waddr;
	logic [DIST_BITS-1:0] dist_wdata;

	always_comb begin
		rows_v = 32'(cfg_wdata[gwdf_pkg::GRID_CFG_W-1:0]);
		if (rows_v == 0) rows_v = 1;
		if (rows_v > MAX_ROWS) rows_v = MAX_ROWS;
		cols_v = 32'(cfg_wdata[gwdf_pkg::GRID_CFG_W-1:0]);
		if (cols_v == 0) cols_v = 1;
		if (cols_v > MAX_COLS) cols_v = MAX_COLS;
		lim_v = 32'(cfg_wdata);
		if (lim_v > DIST_MAX) lim_v = DIST_MAX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= RW'(RST_ROWS);
			cols_q <= CW'(RST_COLS);
			lim_q  <= DIST_BITS'(RST_LIM);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				gwdf_pkg::REG_GRID_ROWS: rows_q <= RW'(rows_v);
				gwdf_pkg::REG_GRID_COLS: cols_q <= CW'(cols_v);
				gwdf_pkg::REG_LIMIT:     lim_q  <= DIST_BITS'(lim_v);
				default: ;
			endcase
		end
	end

	assign row_in    = RW'(item.row);
	assign col_in    = CW'(item.col);
	assign inside_in = (row_in < rows_q) && (col_in < cols_q);
	assign item_addr = {RB'(item_q.row), CB'(item_q.col)};

	// neighbor address of the item cell or of the cell being expanded
	always_comb begin
		base_r = ctl.base_cur ? RW'(cur_addr_q[AW-1:CB]) : RW'(item_q.row);
		base_c = ctl.base_cur ? CW'(cur_addr_q[CB-1:0])  : CW'(item_q.col);
		nb_r   = base_r;
		nb_c   = base_c;
		nb_ok  = 1'b1;
		unique case (ctl.sel)
			gwdf_pkg::SEL_UP: begin
				nb_r  = base_r - 1'b1;
				nb_ok = (base_r != '0);
			end
			gwdf_pkg::SEL_DOWN: begin
				nb_r  = base_r + 1'b1;
				nb_ok = (nb_r < rows_q);
			end
			gwdf_pkg::SEL_LEFT: begin
				nb_c  = base_c - 1'b1;
				nb_ok = (base_c != '0);
			end
			gwdf_pkg::SEL_RIGHT: begin
				nb_c  = base_c + 1'b1;
				nb_ok = (nb_c < cols_q);
			end
			default: ;
		endcase
		nb_addr = {nb_r[RB-1:0], nb_c[CB-1:0]};
	end

	assign d_next   = cur_d_q + 1'b1;
	assign relax_go = ctl.relax && ok_rd_q && !wall_rd_q && (dist_rd_q == '0);
	assign cand     = (ok_rd_q && !wall_rd_q) ? dist_rd_q : '0;

	// single write port per memory
	always_comb begin
		dist_we    = 1'b0;
		dist_waddr = sweep_q;
		dist_wdata = '0;
		wall_we    = 1'b0;
		wall_waddr = sweep_q;
		wall_wdata = 1'b0;
		q_push     = 1'b0;
		q_wdata    = {addr_rd_q, d_next};
		priority if (ctl.init_clr) begin
			dist_we = 1'b1;
			wall_we = 1'b1;
		end else if (ctl.fill_clr) begin
			dist_we = 1'b1;
		end else if (ctl.wr_cell) begin
			dist_we    = inside_q;
			dist_waddr = item_addr;
			wall_we    = inside_q;
			wall_waddr = item_addr;
			wall_wdata = item_q.blocked;
		end else if (ctl.seed) begin
			dist_we    = 1'b1;
			dist_waddr = item_addr;
			dist_wdata = DIST_BITS'(1);
			q_push     = 1'b1;
			q_wdata    = {item_addr, DIST_BITS'(1)};
		end else if (relax_go) begin
			dist_we    = 1'b1;
			dist_waddr = addr_rd_q;
			dist_wdata = d_next;
			q_push     = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (dist_we) dist_mem[dist_waddr] <= dist_wdata;
		if (wall_we) wall_mem[wall_waddr] <= wall_wdata;
		if (q_push)  queue_mem[tail_q[AW-1:0]] <= q_wdata;
		dist_rd_q <= dist_mem[nb_addr];
		wall_rd_q <= wall_mem[nb_addr];
		qd_rd_q   <= queue_mem[head_q[AW-1:0]];
		ok_rd_q   <= nb_ok;
		addr_rd_q <= nb_addr;
	end

	// payload
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			item_q     <= item;
			inside_q   <= inside_in;
			res_dir_q  <= gwdf_pkg::SEL_CENTER;
			res_dist_q <= '0;
			res_wall_q <= 1'b0;
			res_goal_q <= 1'b0;
			best_q     <= '0;
		end
		if (ctl.cur_load) begin
			cur_addr_q <= qd_rd_q[QW-1:DIST_BITS];
			cur_d_q    <= qd_rd_q[DIST_BITS-1:0];
		end
		if (ctl.wall_res) res_wall_q <= 1'b1;
		if (ctl.seed) begin
			res_goal_q <= 1'b1;
			res_dist_q <= DIST_BITS'(1);
		end
		if (ctl.q_eval) begin
			if (ctl.sel == gwdf_pkg::SEL_CENTER) begin
				res_wall_q <= wall_rd_q;
				res_dist_q <= wall_rd_q ? '0 : dist_rd_q;
			end else if (cand != '0 &&
			             (res_dir_q == gwdf_pkg::SEL_CENTER || cand < best_q)) begin
				best_q    <= cand;
				res_dir_q <= ctl.sel;
			end
		end
		if (ctl.publish) begin
			result_q.direction   <= res_dir_q;
			result_q.distance    <= DO_W'(res_dist_q);
			result_q.is_wall     <= res_wall_q;
			result_q.goal_inside <= res_goal_q;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q        <= '0;
			head_q         <= '0;
			tail_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (ctl.init_clr || ctl.fill_clr) sweep_q <= sweep_q + 1'b1;
			if (ctl.q_init) begin
				head_q <= '0;
				tail_q <= '0;
			end else begin
				if (ctl.q_pop) head_q <= head_q + 1'b1;
				if (q_push)    tail_q <= tail_q + 1'b1;
			end
			if (ctl.publish)
				result_valid_q <= 1'b1;
			else if (!result_stall)
				result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign st.cmd        = item_q.cmd;
	assign st.in_grid    = inside_q;
	assign st.sweep_last = (sweep_q == {AW{1'b1}});
	assign st.q_empty    = (head_q == tail_q);
	assign st.cur_stop   = (qd_rd_q[DIST_BITS-1:0] >= lim_q);
	assign st.rd_wall    = wall_rd_q;
	assign st.out_free   = !result_valid_q || !result_stall;

endmodule

[src/grid_wavefront_distance_fill_core.sv]
// Top level of the grid wavefront distance fill block.
// After reset the block runs a clearing pass over the cell memory, one cell a cycle,
// before it takes the first item. A query reads the center and the four neighbors one
// after another through the single cell-memory read port. A fill first clears every
// distance in the same one-cell-a-cycle sweep, then runs a breadth-first flood: each
// dequeued cell is popped and loaded, then each of its four neighbors is read and
// checked in turn through the cell memory port.
// A finished result sits in an output register until transferred.
module grid_wavefront_distance_fill_core #(
	parameter int MAX_ROWS  = gwdf_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS  = gwdf_pkg::DEF_MAX_COLS,
	parameter int DIST_BITS = gwdf_pkg::DEF_DIST_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  gwdf_pkg::item_t                item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output gwdf_pkg::result_t              result,
	input  logic                           cfg_we,
	input  logic [gwdf_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [gwdf_pkg::CFG_W-1:0]     cfg_wdata
);

	gwdf_pkg::ctl_t    ctl;
	gwdf_pkg::status_t st;

	gwdf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.st         (st),
		.ctl        (ctl)
	);

	gwdf_dp #(
		.MAX_ROWS  (MAX_ROWS),
		.MAX_COLS  (MAX_COLS),
		.DIST_BITS (DIST_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.ctl          (ctl),
		.st           (st)
	);

endmodule

[tb/sv/grid_wavefront_distance_fill_core_test.sv]
// Testbench for grid_wavefront_distance_fill_core: directed and random items, self-checking.
module grid_wavefront_distance_fill_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import gwdf_pkg::*;

	localparam int NCELLS = DEF_MAX_ROWS * DEF_MAX_COLS;

	// Tracks cell contents and registers, predicts each result, checks arrivals.
	class route_scoreboard;
		bit          wall_m[NCELLS];
		int unsigned dist_m[NCELLS];
		int unsigned rows_reg = RST_GRID_ROWS, cols_reg = RST_GRID_COLS, lim_reg = RST_LIMIT;
		result_t     pending_q[$];
		int          mismatches = 0;

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			if (idx == REG_GRID_ROWS) rows_reg = val[GRID_CFG_W-1:0];
			else if (idx == REG_GRID_COLS) cols_reg = val[GRID_CFG_W-1:0];
			else if (idx == REG_LIMIT) lim_reg = val;
		endfunction

		function int unsigned rows_in_use();
			return rows_reg == 0 ? 1 : (rows_reg > DEF_MAX_ROWS ? DEF_MAX_ROWS : rows_reg);
		endfunction

		function int unsigned cols_in_use();
			return cols_reg == 0 ? 1 : (cols_reg > DEF_MAX_COLS ? DEF_MAX_COLS : cols_reg);
		endfunction

		function bit on_grid(int r, int c);
			return r >= 0 && c >= 0 && r < rows_in_use() && c < cols_in_use();
		endfunction

		function int unsigned dist_of(int r, int c);
			int i;
			if (!on_grid(r, c)) return 0;
			i = r * DEF_MAX_COLS + c;
			return wall_m[i] ? 0 : dist_m[i];
		endfunction

		function void flood_from(int start);
			int frontier[$];
			int i, r, c, k, nr, nc, n;
			frontier.push_back(start);
			while (frontier.size() > 0) begin
				i = frontier.pop_front();
				r = i / DEF_MAX_COLS;
				c = i % DEF_MAX_COLS;
				if (dist_m[i] >= lim_reg) continue;
				for (k = 0; k < 4; k++) begin
					nr = r + (k == 0 ? -1 : (k == 1 ? 1 : 0));
					nc = c + (k == 2 ? -1 : (k == 3 ? 1 : 0));
					if (!on_grid(nr, nc)) continue;
					n = nr * DEF_MAX_COLS + nc;
					if (wall_m[n] || dist_m[n] != 0) continue;
					dist_m[n] = dist_m[i] + 1;
					frontier.push_back(n);
				end
			end
		endfunction

		function void note_item(item_t it);
			result_t     res;
			bit          ins;
			int          idx, k;
			int unsigned nd[4];
			int unsigned best;
			res = '0;
			ins = on_grid(it.row, it.col);
			idx = it.row * DEF_MAX_COLS + it.col;
			if (it.cmd == CMD_WRITE) begin
				if (ins) begin
					wall_m[idx] = it.blocked;
					dist_m[idx] = 0;
				end
			end else if (it.cmd == CMD_FILL) begin
				for (k = 0; k < NCELLS; k++)
					if (!wall_m[k]) dist_m[k] = 0;
				if (ins) begin
					if (wall_m[idx]) begin
						res.is_wall = 1'b1;
					end else begin
						dist_m[idx] = 1;
						flood_from(idx);
						res.goal_inside = 1'b1;
						res.distance = DIST_OUT_W'(1);
					end
				end
			end else if (it.cmd == CMD_QUERY && ins) begin
				res.is_wall = wall_m[idx];
				res.distance = DIST_OUT_W'(wall_m[idx] ? 0 : dist_m[idx]);
				nd[0] = dist_of(it.row - 1, it.col);
				nd[1] = dist_of(it.row + 1, it.col);
				nd[2] = dist_of(it.row, it.col - 1);
				nd[3] = dist_of(it.row, it.col + 1);
				best = 0;
				for (k = 0; k < 4; k++)
					if (nd[k] != 0 && (res.direction == SEL_CENTER || nd[k] < best)) begin
						best = nd[k];
						res.direction = DIR_W'(SEL_UP + k);
					end
			end
			pending_q.push_back(res);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
				return;
			end
			want = pending_q.pop_front();
			if (got.direction !== want.direction || got.distance !== want.distance ||
					got.is_wall !== want.is_wall || got.goal_inside !== want.goal_inside) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch: expected dir %0d dist %0d wall %0d goal %0d,",
						" got dir %0d dist %0d wall %0d goal %0d"},
						want.direction, want.distance, want.is_wall, want.goal_inside,
						got.direction, got.distance, got.is_wall, got.goal_inside);
			end
		endfunction
	endclass

	logic                 clk, arst_n;
	logic                 item_valid, item_stall;
	item_t                item;
	logic                 result_valid, result_stall;
	result_t              result;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_wdata;

	route_scoreboard sb;
	int  send_idle_pct = 0, recv_stall_pct = 0;
	int  hold_left = 0;
	bit  hold_req = 0;

	grid_wavefront_distance_fill_core dut (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = 400;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk)
		if (arst_n && result_valid && !result_stall) sb.check_result(result);

	// called at a falling edge; returns at a falling edge after the transfer
	task automatic send_item(item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			item <= item_t'($urandom);
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		sb.note_item(it);
		@(negedge clk);
	endtask

	task automatic send_cmd(logic [1:0] cmd, int r, int c, bit blk);
		item_t it;
		it.cmd = cmd;
		it.row = ROW_W'(r);
		it.col = COL_W'(c);
		it.blocked = blk;
		send_item(it);
	endtask

	task automatic wait_idle();
		item_valid <= 1'b0;
		while (sb.pending_q.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_regs(int rows, int cols, int lim);
		cfg_we <= 1'b1; cfg_idx <= REG_GRID_ROWS; cfg_wdata <= CFG_W'(rows);
		sb.set_reg(REG_GRID_ROWS, CFG_W'(rows));
		@(negedge clk);
		cfg_idx <= REG_GRID_COLS; cfg_wdata <= CFG_W'(cols);
		sb.set_reg(REG_GRID_COLS, CFG_W'(cols));
		@(negedge clk);
		cfg_idx <= REG_LIMIT; cfg_wdata <= CFG_W'(lim);
		sb.set_reg(REG_LIMIT, CFG_W'(lim));
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic random_items(int count);
		item_t it;
		int    pick;
		repeat (count) begin
			pick = $urandom_range(99);
			it.cmd = pick < 55 ? CMD_WRITE :
				(pick < 68 ? CMD_FILL : (pick < 95 ? CMD_QUERY : CMD_UNUSED));
			it.blocked = 1'($urandom_range(1));
			if ($urandom_range(3) != 0) begin
				it.row = ROW_W'($urandom_range(sb.rows_in_use() - 1));
				it.col = COL_W'($urandom_range(sb.cols_in_use() - 1));
			end else begin
				it.row = ROW_W'($urandom_range(63));
				it.col = COL_W'($urandom_range(63));
			end
			send_item(it);
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// block runs its clearing pass after reset
		repeat (4200) @(negedge clk);

		send_idle_pct = 8;
		recv_stall_pct = 67;
		// directed, reset register values
		send_cmd(CMD_WRITE, 1, 0, 1);
		send_cmd(CMD_WRITE, 63, 63, 1);
		send_cmd(CMD_WRITE, 0, 63, 1);
		send_cmd(CMD_WRITE, 0, 63, 0);
		send_cmd(CMD_FILL, 0, 0, 0);
		send_cmd(CMD_QUERY, 0, 1, 0);
		send_cmd(CMD_QUERY, 63, 62, 1);
		send_cmd(CMD_QUERY, 63, 63, 0);
		send_cmd(CMD_QUERY, 2, 0, 0);
		send_cmd(CMD_QUERY, 32, 32, 0);
		send_cmd(CMD_UNUSED, 63, 63, 1);
		send_cmd(CMD_FILL, 63, 63, 0);
		send_cmd(CMD_QUERY, 0, 0, 0);
		send_cmd(CMD_WRITE, 63, 63, 0);
		wait_idle();

		write_regs(8, 8, 255);
		send_cmd(CMD_QUERY, 8, 3, 0);
		send_cmd(CMD_WRITE, 9, 9, 1);
		send_cmd(CMD_FILL, 9, 0, 0);
		send_cmd(CMD_FILL, 7, 7, 0);
		send_cmd(CMD_QUERY, 0, 0, 0);
		random_items(14);
		wait_idle();
		write_regs(1, 64, 3);
		random_items(16);
		wait_idle();

		send_idle_pct = 67;
		recv_stall_pct = 8;
		write_regs(0, 5, 0);
		send_cmd(CMD_FILL, 0, 2, 0);
		send_cmd(CMD_QUERY, 0, 1, 0);
		random_items(14);
		wait_idle();
		write_regs(12, 10, 200);
		random_items(16);
		wait_idle();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_regs(127, 3, 1);
		hold_req = 1;
		// a short query first so its result waits out the hold-off and blocks the input
		send_cmd(CMD_QUERY, 0, 0, 0);
		random_items(16);
		wait_idle();
		write_regs(6, 127, 254);
		random_items(16);
		wait_idle();

		if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
